// File: src/mlfs_pkg.sv
// Shared constants and types for the multilevel feedback scheduler.
`default_nettype none
package mlfs_pkg;
	localparam int MAX_PROCS_DEF  = 32;
	localparam int NUM_LEVELS_DEF = 8;
	localparam int TW             = 16;
	localparam int PW             = 8;
	localparam logic [TW-1:0] TMAX = '1;

	typedef enum logic [2:0] {
		OP_NOP    = 3'd0,
		OP_LOAD   = 3'd1,
		OP_MARK   = 3'd2,
		OP_DEMOTE = 3'd3,
		OP_RUN    = 3'd4
	} op_t;

	typedef struct packed {
		op_t           op;
		logic [TW-1:0] now;
		logic [PW-1:0] pid;
		logic [TW-1:0] arrival;
		logic [TW-1:0] service;
		logic [TW-1:0] runtime;
		logic          fin;
	} cmd_t;
endpackage
`default_nettype wire

// File: src/mlfs_cell.sv
// One process-table cell: holds an entry and passes the selection record on.
`default_nettype none
module mlfs_cell import mlfs_pkg::*; #(
	parameter int MAX_PROCS  = MAX_PROCS_DEF,
	parameter int NUM_LEVELS = NUM_LEVELS_DEF,
	parameter int IDX        = 0,
	localparam int IW = $clog2(MAX_PROCS),
	localparam int LW = $clog2(NUM_LEVELS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cmd_t          cmd,
	input  wire logic [IW-1:0] cmd_idx,
	input  wire logic          in_found,
	input  wire logic [LW-1:0] in_level,
	input  wire logic [TW-1:0] in_arrival,
	input  wire logic [IW-1:0] in_idx,
	input  wire logic [PW-1:0] in_pid,
	input  wire logic [TW-1:0] in_service,
	input  wire logic [TW-1:0] in_runtime,
	input  wire logic [1:0]    in_cnt,
	output logic               out_found,
	output logic [LW-1:0]      out_level,
	output logic [TW-1:0]      out_arrival,
	output logic [IW-1:0]      out_idx,
	output logic [PW-1:0]      out_pid,
	output logic [TW-1:0]      out_service,
	output logic [TW-1:0]      out_runtime,
	output logic [1:0]         out_cnt
);
	logic          occ_q, rdy_q, fin_q;
	logic [LW-1:0] lvl_q;
	logic [TW-1:0] rt_q, arr_q, srv_q;
	logic [PW-1:0] pid_q;
	logic          sel, elig, better;

	assign sel    = (cmd_idx == IW'(IDX));
	assign elig   = occ_q && rdy_q && !fin_q;
	assign better = elig && (!in_found || (lvl_q < in_level) ||
		((lvl_q == in_level) && (arr_q < in_arrival)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			rdy_q <= 1'b0;
			fin_q <= 1'b0;
			lvl_q <= '0;
			rt_q  <= '0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					if (sel) begin
						occ_q <= 1'b1;
						rdy_q <= 1'b0;
						fin_q <= 1'b0;
						lvl_q <= '0;
						rt_q  <= '0;
					end
				end
				OP_MARK: begin
					if (occ_q && !fin_q && (arr_q <= cmd.now))
						rdy_q <= 1'b1;
				end
				OP_DEMOTE: begin
					if (sel && (lvl_q < LW'(NUM_LEVELS - 1)))
						lvl_q <= lvl_q + 1'b1;
				end
				OP_RUN: begin
					if (sel) begin
						rt_q <= cmd.runtime;
						if (cmd.fin) begin
							fin_q <= 1'b1;
							rdy_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && sel) begin
			pid_q <= cmd.pid;
			arr_q <= cmd.arrival;
			srv_q <= cmd.service;
		end
	end

	// selection record, one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_found <= 1'b0;
			out_cnt   <= '0;
		end else begin
			out_found <= in_found || better;
			if (occ_q && rdy_q && (in_cnt != 2'd2))
				out_cnt <= in_cnt + 2'd1;
			else
				out_cnt <= in_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (better) begin
			out_level   <= lvl_q;
			out_arrival <= arr_q;
			out_idx     <= IW'(IDX);
			out_pid     <= pid_q;
			out_service <= srv_q;
			out_runtime <= rt_q;
		end else begin
			out_level   <= in_level;
			out_arrival <= in_arrival;
			out_idx     <= in_idx;
			out_pid     <= in_pid;
			out_service <= in_service;
			out_runtime <= in_runtime;
		end
	end
endmodule
`default_nettype wire

// File: src/multilevel_feedback_scheduler_top.sv
// Multilevel feedback scheduler: load/tick input channel, one result per tick.
// Usage:
//   Input beat (in_valid/in_ready): mode 0 loads a process (proc_id, arrival,
//   service) into the next free table cell; loads beyond MAX_PROCS are dropped
//   and give no result. mode 1 advances one tick and gives one result beat.
//   Output beat (out_valid/out_ready): run_valid/run_pid/run_level of the
//   process that ran, done_res with finish_time and turnaround, all_done.
// Timing:
//   A load is taken on its accepting edge. A tick goes from the accepting
//   edge to the result register through MARK, which marks arrivals, SCAN,
//   in which the selection record ripples through the row of cells, then
//   EVAL and RUN. When a quantum expiry demotes the running process the
//   row is swept again before RUN.
//   One item is in work at a time; in_ready is high only between items.
// Reset: arst_n clears the table, time and out_valid.
// Stall: a finished result waits in the output register; the next tick may
//   be accepted and swept, and stops before its run step until out_ready.
`default_nettype none
module multilevel_feedback_scheduler_top import mlfs_pkg::*; #(
	parameter int MAX_PROCS  = MAX_PROCS_DEF,
	parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          mode,
	input  wire logic [PW-1:0] proc_id,
	input  wire logic [TW-1:0] arrival,
	input  wire logic [TW-1:0] service,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               run_valid,
	output logic [PW-1:0]      run_pid,
	output logic [2:0]         run_level,
	output logic               done_res,
	output logic [TW-1:0]      finish_time,
	output logic [TW-1:0]      turnaround,
	output logic               all_done
);
	localparam int IW = $clog2(MAX_PROCS);
	localparam int LW = $clog2(NUM_LEVELS);
	localparam int CW = $clog2(MAX_PROCS + 1);
	localparam int SW = NUM_LEVELS;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MARK = 5'b00010,
		S_SCAN = 5'b00100,
		S_EVAL = 5'b01000,
		S_RUN  = 5'b10000
	} state_t;

	state_t        state_q;
	logic [IW-1:0] scan_q;
	logic          pass_q;
	logic [TW-1:0] now_q;
	logic [CW-1:0] count_q, nfin_q;
	logic          running_q;
	logic [IW-1:0] cur_idx_q;
	logic [LW-1:0] cur_lvl_q;
	logic [PW-1:0] cur_pid_q;
	logic [TW-1:0] cur_arr_q, cur_srv_q, cur_rt_q;
	logic [SW-1:0] slice_q;

	cmd_t          cmd;
	logic [IW-1:0] cmd_idx;

	logic          lk_found   [MAX_PROCS+1];
	logic [LW-1:0] lk_level   [MAX_PROCS+1];
	logic [TW-1:0] lk_arrival [MAX_PROCS+1];
	logic [IW-1:0] lk_idx     [MAX_PROCS+1];
	logic [PW-1:0] lk_pid     [MAX_PROCS+1];
	logic [TW-1:0] lk_service [MAX_PROCS+1];
	logic [TW-1:0] lk_runtime [MAX_PROCS+1];
	logic [1:0]    lk_cnt     [MAX_PROCS+1];

	assign lk_found[0]   = 1'b0;
	assign lk_level[0]   = '0;
	assign lk_arrival[0] = '0;
	assign lk_idx[0]     = '0;
	assign lk_pid[0]     = '0;
	assign lk_service[0] = '0;
	assign lk_runtime[0] = '0;
	assign lk_cnt[0]     = '0;

	for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
		mlfs_cell #(
			.MAX_PROCS (MAX_PROCS),
			.NUM_LEVELS(NUM_LEVELS),
			.IDX       (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.cmd_idx    (cmd_idx),
			.in_found   (lk_found[g]),
			.in_level   (lk_level[g]),
			.in_arrival (lk_arrival[g]),
			.in_idx     (lk_idx[g]),
			.in_pid     (lk_pid[g]),
			.in_service (lk_service[g]),
			.in_runtime (lk_runtime[g]),
			.in_cnt     (lk_cnt[g]),
			.out_found  (lk_found[g+1]),
			.out_level  (lk_level[g+1]),
			.out_arrival(lk_arrival[g+1]),
			.out_idx    (lk_idx[g+1]),
			.out_pid    (lk_pid[g+1]),
			.out_service(lk_service[g+1]),
			.out_runtime(lk_runtime[g+1]),
			.out_cnt    (lk_cnt[g+1])
		);
	end

	logic          in_acc, load_ok, run_go, expire, demote;
	logic [SW-1:0] quantum;
	logic [TW-1:0] rt_new, now_new;
	logic          fin_new;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign load_ok  = in_acc && !mode && (count_q < CW'(MAX_PROCS));
	assign quantum  = SW'(1) << cur_lvl_q;
	assign expire   = running_q && (slice_q >= quantum);
	assign demote   = expire && (lk_cnt[MAX_PROCS] == 2'd2) &&
		(cur_lvl_q < LW'(NUM_LEVELS - 1));
	assign run_go   = (state_q == S_RUN) && (!out_valid || out_ready);
	assign rt_new   = (cur_rt_q == TMAX) ? cur_rt_q : cur_rt_q + 1'b1;
	assign fin_new  = (rt_new >= cur_srv_q);
	assign now_new  = (now_q == TMAX) ? now_q : now_q + 1'b1;

	always_comb begin
		cmd         = '0;
		cmd.op      = OP_NOP;
		cmd.now     = now_q;
		cmd.pid     = proc_id;
		cmd.arrival = arrival;
		cmd.service = service;
		cmd.runtime = rt_new;
		cmd.fin     = fin_new;
		cmd_idx     = cur_idx_q;
		if (load_ok) begin
			cmd.op  = OP_LOAD;
			cmd_idx = count_q[IW-1:0];
		end else if (state_q == S_MARK) begin
			cmd.op = OP_MARK;
		end else if (state_q == S_EVAL && !pass_q && demote) begin
			cmd.op = OP_DEMOTE;
		end else if (run_go && running_q) begin
			cmd.op = OP_RUN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			scan_q    <= '0;
			pass_q    <= 1'b0;
			now_q     <= '0;
			count_q   <= '0;
			nfin_q    <= '0;
			running_q <= 1'b0;
			cur_idx_q <= '0;
			cur_lvl_q <= '0;
			cur_pid_q <= '0;
			cur_arr_q <= '0;
			cur_srv_q <= '0;
			cur_rt_q  <= '0;
			slice_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (run_go)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (load_ok)
						count_q <= count_q + 1'b1;
					if (in_acc && mode)
						state_q <= S_MARK;
				end
				S_MARK: begin
					scan_q  <= '0;
					pass_q  <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == IW'(MAX_PROCS - 1))
						state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (!pass_q && demote) begin
						running_q <= 1'b0;
						slice_q   <= '0;
						scan_q    <= '0;
						pass_q    <= 1'b1;
						state_q   <= S_SCAN;
					end else begin
						state_q <= S_RUN;
						if (pass_q || !running_q || expire) begin
							running_q <= lk_found[MAX_PROCS];
							slice_q   <= '0;
							cur_idx_q <= lk_idx[MAX_PROCS];
							cur_lvl_q <= lk_level[MAX_PROCS];
							cur_pid_q <= lk_pid[MAX_PROCS];
							cur_arr_q <= lk_arrival[MAX_PROCS];
							cur_srv_q <= lk_service[MAX_PROCS];
							cur_rt_q  <= lk_runtime[MAX_PROCS];
						end
					end
				end
				S_RUN: begin
					if (run_go) begin
						now_q   <= now_new;
						state_q <= S_IDLE;
						if (running_q) begin
							cur_rt_q <= rt_new;
							if (fin_new) begin
								running_q <= 1'b0;
								slice_q   <= '0;
								nfin_q    <= nfin_q + 1'b1;
							end else begin
								slice_q <= slice_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (run_go) begin
			run_valid   <= running_q;
			run_pid     <= running_q ? cur_pid_q : '0;
			run_level   <= running_q ? 3'(cur_lvl_q) : '0;
			done_res    <= running_q && fin_new;
			finish_time <= (running_q && fin_new) ? now_new : '0;
			turnaround  <= (running_q && fin_new && now_new >= cur_arr_q) ?
				now_new - cur_arr_q : '0;
			all_done    <= ((running_q && fin_new) ? nfin_q + 1'b1 : nfin_q) == count_q;
		end
	end
endmodule
`default_nettype wire

// File: src/mlfs_checker.sv
// Port-level checks for the scheduler, bound to the top level.
`default_nettype none
module mlfs_checker import mlfs_pkg::*; (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          mode,
	input wire logic [PW-1:0] proc_id,
	input wire logic [TW-1:0] arrival,
	input wire logic [TW-1:0] service,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire logic          run_valid,
	input wire logic [PW-1:0] run_pid,
	input wire logic [2:0]    run_level,
	input wire logic          done_res,
	input wire logic [TW-1:0] finish_time,
	input wire logic [TW-1:0] turnaround,
	input wire logic          all_done
);
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode |=> !in_ready)
		else $error("tick beat did not hold off input");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !mode && !out_valid |=> !out_valid)
		else $error("load beat produced a result");

	a_done_ran: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> run_valid)
		else $error("completion without a run");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_valid |-> run_pid == '0 && finish_time == '0)
		else $error("idle result carries data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(run_pid))
		else $error("result beat dropped while stalled");
endmodule

bind multilevel_feedback_scheduler_top mlfs_checker u_mlfs_checker (.*);
`default_nettype wire
